[design/bipr_pkg.sv]
// Shared types, codes and decode functions of the bytecode instruction record parser.
package bipr_pkg;

	localparam int unsigned MAX_ARGS = 3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INT   = 2'd1;
	localparam logic [1:0] ST_TOO_MANY  = 2'd2;
	localparam logic [1:0] ST_BAD_KIND  = 2'd3;

	localparam logic [3:0] KIND_UNDEF    = 4'd0;
	localparam logic [3:0] KIND_CONST    = 4'd1;
	localparam logic [3:0] KIND_SLOT     = 4'd2;
	localparam logic [3:0] KIND_COUNT    = 4'd3;
	localparam logic [3:0] KIND_PARAM    = 4'd4;
	localparam logic [3:0] KIND_POSITION = 4'd5;
	localparam logic [3:0] KIND_CLOSURE  = 4'd6;
	localparam logic [3:0] KIND_STATIC   = 4'd7;
	localparam logic [3:0] KIND_ARG      = 4'd8;

	localparam logic [7:0] INT_TAG_W4 = 8'h69;
	localparam logic [7:0] INT_TAG_W3 = 8'h68;
	localparam logic [7:0] INT_TAG_W2 = 8'h73;
	localparam logic [7:0] INT_TAG_W1 = 8'h62;
	localparam logic [7:0] INT_TAG_W0 = 8'h7a;

	localparam logic [7:0] ARG_TAG_CONST    = 8'h63;
	localparam logic [7:0] ARG_TAG_SLOT     = 8'h73;
	localparam logic [7:0] ARG_TAG_COUNT    = 8'h6f;
	localparam logic [7:0] ARG_TAG_PARAM    = 8'h70;
	localparam logic [7:0] ARG_TAG_POSITION = 8'h69;
	localparam logic [7:0] ARG_TAG_CLOSURE  = 8'h6c;
	localparam logic [7:0] ARG_TAG_STATIC   = 8'h74;
	localparam logic [7:0] ARG_TAG_ARG      = 8'h61;

	typedef struct packed {
		logic [31:0] line_number;
		logic [7:0]  opcode;
		logic [1:0]  arg_count;
		logic [3:0]  first_kind;
		logic [31:0] first_value;
		logic [3:0]  second_kind;
		logic [31:0] second_value;
		logic [3:0]  third_kind;
		logic [31:0] third_value;
		logic [1:0]  status;
	} rec_t;

	typedef struct packed {
		logic       known;
		logic [2:0] len;
	} int_tag_t;

	function automatic int_tag_t int_tag_len(input logic [7:0] t);
		int_tag_t r;
		r = '{known: 1'b1, len: 3'd0};
		unique case (t)
			INT_TAG_W4: r.len = 3'd4;
			INT_TAG_W3: r.len = 3'd3;
			INT_TAG_W2: r.len = 3'd2;
			INT_TAG_W1: r.len = 3'd1;
			INT_TAG_W0: r.len = 3'd0;
			default: r.known = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] kind_code(input logic [7:0] t);
		logic [3:0] k;
		unique case (t)
			ARG_TAG_CONST:    k = KIND_CONST;
			ARG_TAG_SLOT:     k = KIND_SLOT;
			ARG_TAG_COUNT:    k = KIND_COUNT;
			ARG_TAG_PARAM:    k = KIND_PARAM;
			ARG_TAG_POSITION: k = KIND_POSITION;
			ARG_TAG_CLOSURE:  k = KIND_CLOSURE;
			ARG_TAG_STATIC:   k = KIND_STATIC;
			ARG_TAG_ARG:      k = KIND_ARG;
			default: k = KIND_UNDEF;
		endcase
		return k;
	endfunction

	// Argument index modulo three on a two-bit index.
	function automatic logic [1:0] arg_slot(input logic [1:0] idx);
		return (idx == 2'd3) ? 2'd0 : idx;
	endfunction

endpackage

[design/bipr_parser.sv]
// Record assembly state machine: one byte per cycle while accept is high, at most one record out.
module bipr_parser
	import bipr_pkg::*;
#(
	parameter int unsigned MAX_ARG_COUNT = MAX_ARGS
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] byte_value,
	output logic       res_valid,
	output rec_t       res
);

	localparam logic [2:0] PH_LINE_TAG  = 3'd0;
	localparam logic [2:0] PH_LINE_BYTE = 3'd1;
	localparam logic [2:0] PH_OPCODE    = 3'd2;
	localparam logic [2:0] PH_COUNT     = 3'd3;
	localparam logic [2:0] PH_KIND      = 3'd4;
	localparam logic [2:0] PH_VAL_TAG   = 3'd5;
	localparam logic [2:0] PH_VAL_BYTE  = 3'd6;

	logic [2:0]       phase_q, n_phase;
	logic [2:0]       left_q, n_left;
	logic [31:0]      acc_q, n_acc;
	logic [31:0]      line_q, n_line;
	logic [7:0]       opc_q, n_opc;
	logic [1:0]       cnt_q, n_cnt;
	logic [1:0]       idx_q, n_idx;
	logic [2:0][3:0]  kinds_q, n_kinds;
	logic [2:0][31:0] vals_q, n_vals;

	int_tag_t    tag;
	logic        int_fire;
	logic        int_line;
	logic [31:0] int_val;
	logic [2:0]  left_dec;
	logic [1:0]  slot;
	logic        do_rec;
	logic        do_err;
	logic [1:0]  err_code;

	always_comb begin
		n_phase  = phase_q;
		n_left   = left_q;
		n_acc    = acc_q;
		n_line   = line_q;
		n_opc    = opc_q;
		n_cnt    = cnt_q;
		n_idx    = idx_q;
		n_kinds  = kinds_q;
		n_vals   = vals_q;
		int_fire = 1'b0;
		int_line = 1'b0;
		int_val  = '0;
		do_rec   = 1'b0;
		do_err   = 1'b0;
		err_code = ST_OK;
		tag      = int_tag_len(byte_value);
		left_dec = (left_q != 3'd0) ? left_q - 3'd1 : 3'd0;
		slot     = arg_slot(idx_q);
		res      = '0;

		unique case (phase_q)
			PH_LINE_BYTE, PH_VAL_BYTE: begin
				n_acc  = {acc_q[23:0], byte_value};
				n_left = left_dec;
				if (left_dec == 3'd0) begin
					int_fire = 1'b1;
					int_line = (phase_q == PH_LINE_BYTE);
					int_val  = n_acc;
				end
			end
			PH_OPCODE: begin
				n_opc   = byte_value;
				n_phase = PH_COUNT;
			end
			PH_COUNT: begin
				if (byte_value > 8'(MAX_ARG_COUNT)) begin
					do_err   = 1'b1;
					err_code = ST_TOO_MANY;
				end else begin
					n_cnt = byte_value[1:0];
					n_idx = 2'd0;
					if (byte_value == 8'd0)
						do_rec = 1'b1;
					else
						n_phase = PH_KIND;
				end
			end
			PH_KIND: begin
				n_kinds[slot] = kind_code(byte_value);
				n_phase       = PH_VAL_TAG;
			end
			default: begin
				if (!tag.known) begin
					do_err   = 1'b1;
					err_code = ST_BAD_INT;
				end else begin
					n_acc = '0;
					if (tag.len == 3'd0) begin
						int_fire = 1'b1;
						int_line = (phase_q != PH_VAL_TAG);
					end else begin
						n_left  = tag.len;
						n_phase = (phase_q == PH_VAL_TAG) ? PH_VAL_BYTE : PH_LINE_BYTE;
					end
				end
			end
		endcase

		if (int_fire) begin
			if (int_line) begin
				n_line  = int_val;
				n_phase = PH_OPCODE;
			end else if (kinds_q[slot] == KIND_UNDEF) begin
				do_err   = 1'b1;
				err_code = ST_BAD_KIND;
			end else begin
				n_vals[slot] = int_val;
				n_idx        = idx_q + 2'd1;
				if (n_idx >= cnt_q)
					do_rec = 1'b1;
				else
					n_phase = PH_KIND;
			end
		end

		if (do_rec) begin
			res.line_number  = n_line;
			res.opcode       = n_opc;
			res.arg_count    = n_cnt;
			res.first_kind   = n_kinds[0];
			res.first_value  = n_vals[0];
			res.second_kind  = n_kinds[1];
			res.second_value = n_vals[1];
			res.third_kind   = n_kinds[2];
			res.third_value  = n_vals[2];
			res.status       = ST_OK;
		end else if (do_err) begin
			res.status = err_code;
		end

		res_valid = do_rec || do_err;
		if (res_valid) begin
			n_phase = PH_LINE_TAG;
			n_left  = '0;
			n_acc   = '0;
			n_line  = '0;
			n_opc   = '0;
			n_cnt   = '0;
			n_idx   = '0;
			n_kinds = '0;
			n_vals  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE_TAG;
			left_q  <= '0;
			acc_q   <= '0;
			line_q  <= '0;
			opc_q   <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			kinds_q <= '0;
			vals_q  <= '0;
		end else if (accept) begin
			phase_q <= n_phase;
			left_q  <= n_left;
			acc_q   <= n_acc;
			line_q  <= n_line;
			opc_q   <= n_opc;
			cnt_q   <= n_cnt;
			idx_q   <= n_idx;
			kinds_q <= n_kinds;
			vals_q  <= n_vals;
		end
	end

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid |=> phase_q == PH_LINE_TAG && kinds_q == '0)
		else $error("Parser state not cleared after a result.");

	a_error_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK |-> res.line_number == '0 && res.arg_count == '0)
		else $error("Error result carries record fields.");

	a_phase_known: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_VAL_BYTE)
		else $error("Parser phase left the defined range.");

endmodule

[design/bipr_out_buf.sv]
// Two-entry output register with skid stage for finished records.
module bipr_out_buf
	import bipr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic can_take,
	output logic out_valid,
	input  logic out_ready,
	output rec_t out_rec
);

	logic out_v_q;
	logic skid_v_q;
	rec_t out_q;
	rec_t skid_q;
	logic pop;

	assign pop       = out_v_q && out_ready;
	assign can_take  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_rec   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop)
				skid_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q || pop)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_v_q || pop)
				out_q <= push_rec;
			else
				skid_q <= push_rec;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("Skid entry held without an output entry.");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !skid_v_q && !out_v_q |=> out_v_q && !skid_v_q)
		else $error("Record pushed into empty buffer was not presented.");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ready |=> out_v_q && $stable(out_q))
		else $error("Output item changed while waiting to be taken.");

endmodule

[design/bytecode_instruction_record_parser_top.sv]
// Top level of the bytecode instruction record parser.
//
//   channel | direction | handshake             | payload
//   input   | in        | in_valid / in_ready   | byte_value
//   output  | out       | out_valid / out_ready | line_number .. status (one record)
//
// The state machine steps once per byte, so one byte is taken per cycle while
// in_ready is high; the record or error that a byte completes is presented in
// the cycle after that byte is taken when the output register is free.
// Reset is asynchronous and returns the parser to the start of a record.
// A skid stage holds a second finished record, so bytes keep flowing while the
// output is stalled until both entries are full.
module bytecode_instruction_record_parser_top
	import bipr_pkg::*;
#(
	parameter int unsigned MAX_ARG_COUNT = MAX_ARGS
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] line_number,
	output logic [7:0]  opcode,
	output logic [1:0]  arg_count,
	output logic [3:0]  first_kind,
	output logic [31:0] first_value,
	output logic [3:0]  second_kind,
	output logic [31:0] second_value,
	output logic [3:0]  third_kind,
	output logic [31:0] third_value,
	output logic [1:0]  status
);

	logic accept;
	logic res_valid;
	rec_t res;
	rec_t out_rec;
	logic can_take;

	assign in_ready = can_take;
	assign accept   = in_valid && can_take;

	bipr_parser #(
		.MAX_ARG_COUNT (MAX_ARG_COUNT)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.byte_value (byte_value),
		.res_valid  (res_valid),
		.res        (res)
	);

	bipr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_rec  (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rec   (out_rec)
	);

	assign line_number  = out_rec.line_number;
	assign opcode       = out_rec.opcode;
	assign arg_count    = out_rec.arg_count;
	assign first_kind   = out_rec.first_kind;
	assign first_value  = out_rec.first_value;
	assign second_kind  = out_rec.second_kind;
	assign second_value = out_rec.second_value;
	assign third_kind   = out_rec.third_kind;
	assign third_value  = out_rec.third_value;
	assign status       = out_rec.status;

endmodule

[tb/parse_record_checker.sv]
// Checker that predicts and compares instruction records.
`timescale 1ns / 1ps

module parse_record_checker
	import bipr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] line_number,
	input  logic [7:0]  opcode,
	input  logic [1:0]  arg_count,
	input  logic [3:0]  first_kind,
	input  logic [31:0] first_value,
	input  logic [3:0]  second_kind,
	input  logic [31:0] second_value,
	input  logic [3:0]  third_kind,
	input  logic [31:0] third_value,
	input  logic [1:0]  status,
	output int          mismatch_count,
	output int          pending_records
);

	localparam int NOT_AN_INT_TAG = -1;

	typedef enum logic [3:0] {
		AWAIT_LINE_TAG,
		LINE_BYTES,
		AWAIT_OPCODE,
		AWAIT_COUNT,
		AWAIT_KIND,
		AWAIT_VALUE_TAG,
		VALUE_BYTES
	} parse_phase_e;

	parse_phase_e phase_q;
	logic [2:0]   bytes_left_q;
	logic [31:0]  acc_q;
	logic [31:0]  line_q;
	logic [7:0]   opcode_q;
	logic [1:0]   count_q;
	logic [1:0]   arg_idx_q;
	logic [3:0]   kinds_q [3];
	logic [31:0]  values_q [3];

	rec_t expected_records [$];

	function automatic int tag_width(input logic [7:0] b);
		case (b)
			INT_TAG_W4: return 4;
			INT_TAG_W3: return 3;
			INT_TAG_W2: return 2;
			INT_TAG_W1: return 1;
			INT_TAG_W0: return 0;
			default: return NOT_AN_INT_TAG;
		endcase
	endfunction

	function automatic logic [3:0] kind_of(input logic [7:0] b);
		case (b)
			ARG_TAG_CONST:    return KIND_CONST;
			ARG_TAG_SLOT:     return KIND_SLOT;
			ARG_TAG_COUNT:    return KIND_COUNT;
			ARG_TAG_PARAM:    return KIND_PARAM;
			ARG_TAG_POSITION: return KIND_POSITION;
			ARG_TAG_CLOSURE:  return KIND_CLOSURE;
			ARG_TAG_STATIC:   return KIND_STATIC;
			ARG_TAG_ARG:      return KIND_ARG;
			default: return KIND_UNDEF;
		endcase
	endfunction

	task automatic clear_record_state();
		phase_q = AWAIT_LINE_TAG;
		bytes_left_q = '0;
		acc_q = '0;
		line_q = '0;
		opcode_q = '0;
		count_q = '0;
		arg_idx_q = '0;
		for (int i = 0; i < 3; i++) begin
			kinds_q[i] = KIND_UNDEF;
			values_q[i] = '0;
		end
	endtask

	task automatic push_error(input logic [1:0] code);
		rec_t rec;
		rec = '0;
		rec.status = code;
		expected_records.push_back(rec);
		clear_record_state();
	endtask

	task automatic push_record();
		rec_t rec;
		rec.line_number = line_q;
		rec.opcode = opcode_q;
		rec.arg_count = count_q;
		rec.first_kind = kinds_q[0];
		rec.first_value = values_q[0];
		rec.second_kind = kinds_q[1];
		rec.second_value = values_q[1];
		rec.third_kind = kinds_q[2];
		rec.third_value = values_q[2];
		rec.status = ST_OK;
		expected_records.push_back(rec);
		clear_record_state();
	endtask

	task automatic integer_complete();
		int slot;
		if (phase_q == AWAIT_LINE_TAG || phase_q == LINE_BYTES) begin
			line_q = acc_q;
			phase_q = AWAIT_OPCODE;
		end else begin
			slot = arg_idx_q % 3;
			if (kinds_q[slot] == KIND_UNDEF) begin
				push_error(ST_BAD_KIND);
			end else begin
				values_q[slot] = acc_q;
				arg_idx_q = arg_idx_q + 2'd1;
				if (arg_idx_q >= count_q)
					push_record();
				else
					phase_q = AWAIT_KIND;
			end
		end
	endtask

	task automatic integer_tag(input logic [7:0] b, input parse_phase_e byte_phase);
		int width;
		width = tag_width(b);
		if (width == NOT_AN_INT_TAG) begin
			push_error(ST_BAD_INT);
		end else begin
			acc_q = '0;
			if (width == 0) begin
				integer_complete();
			end else begin
				bytes_left_q = width[2:0];
				phase_q = byte_phase;
			end
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		case (phase_q)
			LINE_BYTES, VALUE_BYTES: begin
				acc_q = {acc_q[23:0], b};
				if (bytes_left_q != 0)
					bytes_left_q = bytes_left_q - 3'd1;
				if (bytes_left_q == 0)
					integer_complete();
			end
			AWAIT_OPCODE: begin
				opcode_q = b;
				phase_q = AWAIT_COUNT;
			end
			AWAIT_COUNT: begin
				if (b > MAX_ARGS) begin
					push_error(ST_TOO_MANY);
				end else begin
					count_q = b[1:0];
					arg_idx_q = '0;
					if (b == 0)
						push_record();
					else
						phase_q = AWAIT_KIND;
				end
			end
			AWAIT_KIND: begin
				kinds_q[arg_idx_q % 3] = kind_of(b);
				phase_q = AWAIT_VALUE_TAG;
			end
			AWAIT_VALUE_TAG: begin
				integer_tag(b, VALUE_BYTES);
			end
			default: begin
				phase_q = AWAIT_LINE_TAG;
				integer_tag(b, LINE_BYTES);
			end
		endcase
	endtask

	task automatic report_failure(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			report_failure($sformatf("%s expected %0h got %0h", name, want, got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		rec_t want;
		if (!arst_n) begin
			clear_record_state();
			expected_records.delete();
			mismatch_count = 0;
			pending_records <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_records.size() == 0) begin
					report_failure($sformatf("record with status %0d arrived with none pending",
						status));
				end else begin
					want = expected_records.pop_front();
					compare_field("line_number", want.line_number, line_number);
					compare_field("opcode", want.opcode, opcode);
					compare_field("arg_count", want.arg_count, arg_count);
					compare_field("first_kind", want.first_kind, first_kind);
					compare_field("first_value", want.first_value, first_value);
					compare_field("second_kind", want.second_kind, second_kind);
					compare_field("second_value", want.second_value, second_value);
					compare_field("third_kind", want.third_kind, third_kind);
					compare_field("third_value", want.third_value, third_value);
					compare_field("status", want.status, status);
				end
			end
			if (in_valid && in_ready)
				predict_byte(byte_value);
			pending_records <= expected_records.size();
		end
	end

endmodule

[tb/bytecode_instruction_record_parser_top_test.sv]
// Stimulus, clock, reset and verdict for the bytecode instruction record parser.
`timescale 1ns / 1ps

module bytecode_instruction_record_parser_top_test;

	import bipr_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 20;

	typedef enum int {
		FLAW_NONE,
		FLAW_LINE_TAG,
		FLAW_COUNT,
		FLAW_ARG_TAG,
		FLAW_VALUE_TAG,
		FLAW_NOISE
	} flaw_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_value;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] line_number;
	logic [7:0]  opcode;
	logic [1:0]  arg_count;
	logic [3:0]  first_kind;
	logic [31:0] first_value;
	logic [3:0]  second_kind;
	logic [31:0] second_value;
	logic [3:0]  third_kind;
	logic [31:0] third_value;
	logic [1:0]  status;

	int   mismatch_count;
	int   pending_records;
	int   bytes_sent = 0;
	bit   tx_idle_on = 1'b0;
	bit   rx_idle_on = 1'b0;
	logic rx_hold_request = 1'b0;

	always #5 clk = ~clk;

	bytecode_instruction_record_parser_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_number(line_number),
		.opcode(opcode),
		.arg_count(arg_count),
		.first_kind(first_kind),
		.first_value(first_value),
		.second_kind(second_kind),
		.second_value(second_value),
		.third_kind(third_kind),
		.third_value(third_value),
		.status(status)
	);

	parse_record_checker record_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_number(line_number),
		.opcode(opcode),
		.arg_count(arg_count),
		.first_kind(first_kind),
		.first_value(first_value),
		.second_kind(second_kind),
		.second_value(second_value),
		.third_kind(third_kind),
		.third_value(third_value),
		.status(status),
		.mismatch_count(mismatch_count),
		.pending_records(pending_records)
	);

	function automatic logic [7:0] bad_int_tag();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == INT_TAG_W4 || b == INT_TAG_W3 || b == INT_TAG_W2 || b == INT_TAG_W1
			|| b == INT_TAG_W0);
		return b;
	endfunction

	function automatic logic [7:0] bad_arg_tag();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == ARG_TAG_CONST || b == ARG_TAG_SLOT || b == ARG_TAG_COUNT
			|| b == ARG_TAG_PARAM || b == ARG_TAG_POSITION || b == ARG_TAG_CLOSURE
			|| b == ARG_TAG_STATIC || b == ARG_TAG_ARG);
		return b;
	endfunction

	function automatic logic [7:0] random_arg_tag();
		case ($urandom_range(0, 7))
			0: return ARG_TAG_CONST;
			1: return ARG_TAG_SLOT;
			2: return ARG_TAG_COUNT;
			3: return ARG_TAG_PARAM;
			4: return ARG_TAG_POSITION;
			5: return ARG_TAG_CLOSURE;
			6: return ARG_TAG_STATIC;
			default: return ARG_TAG_ARG;
		endcase
	endfunction

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic offer_byte(input logic [7:0] b);
		if (tx_idle_on && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_int(input logic [31:0] v, input int width);
		logic [7:0] tag;
		case (width)
			4: tag = INT_TAG_W4;
			3: tag = INT_TAG_W3;
			2: tag = INT_TAG_W2;
			1: tag = INT_TAG_W1;
			default: tag = INT_TAG_W0;
		endcase
		offer_byte(tag);
		for (int i = width - 1; i >= 0; i--)
			offer_byte(v[8 * i +: 8]);
	endtask

	// Mostly well-formed records with random content; the rest are broken records or noise.
	task automatic send_random_stream(input int stop_at);
		flaw_e flaw;
		int n_args;
		int bad_pos;
		while (bytes_sent < stop_at) begin
			flaw = ($urandom_range(0, 99) < 15) ? flaw_e'($urandom_range(1, 5)) : FLAW_NONE;
			if (flaw == FLAW_NOISE) begin
				repeat ($urandom_range(1, 6)) offer_byte(8'($urandom_range(0, 255)));
			end else if (flaw == FLAW_LINE_TAG) begin
				offer_byte(bad_int_tag());
			end else begin
				send_int(random_value(), $urandom_range(0, 4));
				offer_byte(8'($urandom_range(0, 255)));
				if (flaw == FLAW_COUNT) begin
					offer_byte(8'($urandom_range(MAX_ARGS + 1, 255)));
				end else begin
					n_args = (flaw == FLAW_NONE) ? $urandom_range(0, 3) : $urandom_range(1, 3);
					bad_pos = (flaw == FLAW_NONE) ? -1 : $urandom_range(0, n_args - 1);
					offer_byte(n_args[7:0]);
					for (int i = 0; i < n_args; i++) begin
						if (i == bad_pos && flaw == FLAW_ARG_TAG)
							offer_byte(bad_arg_tag());
						else
							offer_byte(random_arg_tag());
						if (i == bad_pos && flaw == FLAW_VALUE_TAG) begin
							offer_byte(bad_int_tag());
							break;
						end
						send_int(random_value(), $urandom_range(0, 4));
						if (i == bad_pos)
							break;
					end
				end
			end
		end
	endtask

	initial begin : receiver
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_request) begin
				rx_hold_request <= 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 13)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		byte_value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		// Widest record: full line number, top opcode, three arguments of mixed widths.
		send_int(32'hFFFF_FFFF, 4);
		offer_byte(8'hFF);
		offer_byte(8'd3);
		offer_byte(ARG_TAG_CONST);
		send_int('0, 0);
		offer_byte(ARG_TAG_SLOT);
		send_int(32'h0000_00FF, 1);
		offer_byte(ARG_TAG_ARG);
		send_int(32'h8000_0001, 4);
		// Zero-byte line number and a record without arguments.
		send_int('0, 0);
		offer_byte(8'h00);
		offer_byte(8'd0);
		// Unknown tag where the line number should start.
		offer_byte(bad_int_tag());
		// Argument count above the limit.
		send_int(32'h0012_3456, 3);
		offer_byte(8'h5A);
		offer_byte(8'd4);
		// Unknown argument tag, reported once its value has been read.
		send_int(32'h0000_0102, 2);
		offer_byte(8'hA5);
		offer_byte(8'd1);
		offer_byte(bad_arg_tag());
		send_int(32'h0000_007E, 1);
		// Unknown argument tag followed by an unknown value tag.
		send_int('0, 0);
		offer_byte(8'h3C);
		offer_byte(8'd2);
		offer_byte(ARG_TAG_POSITION);
		send_int(32'h0000_1234, 2);
		offer_byte(bad_arg_tag());
		offer_byte(bad_int_tag());

		send_random_stream(450);

		// The receiver holds off while short records keep coming, so the input stalls.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_request <= 1'b1;
		repeat (12) begin
			send_int(random_value(), $urandom_range(0, 4));
			offer_byte(8'($urandom_range(0, 255)));
			offer_byte(8'd0);
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_records != 0);

		send_random_stream(700);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_random_stream(1150);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_random_stream(1400);

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_records != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_records == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
